>>> hdl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, codes and the character-to-sextet map of the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    // Depth of the job queue between the front and the back.
    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);

    // Special sextet codes.
    localparam logic [6:0] PadCode = 7'd64;
    localparam logic [6:0] BadCode = 7'd127;

    // Character codes of the alphabet.
    localparam logic [7:0] ChUpA   = 8'h41;
    localparam logic [7:0] ChUpZ   = 8'h5A;
    localparam logic [7:0] ChLoA   = 8'h61;
    localparam logic [7:0] ChLoZ   = 8'h7A;
    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChNine  = 8'h39;
    localparam logic [7:0] ChPlus  = 8'h2B;
    localparam logic [7:0] ChMinus = 8'h2D;
    localparam logic [7:0] ChSlash = 8'h2F;
    localparam logic [7:0] ChUnder = 8'h5F;
    localparam logic [7:0] ChEqual = 8'h3D;

    typedef logic [6:0] sextet_t;

    // Input word: one character.
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } char_word_t;

    // Output word: one decoded result.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       final_result;
        logic       halted_flag;
    } byte_word_t;

    // One decoded group waiting to be sent: one to three results.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            present;
        logic            last;
        logic            halt;
    } job_t;

    // Map a character to its sextet, the pad code or the invalid code.
    function automatic sextet_t sextet_of(input logic [7:0] c);
        sextet_t code;
        unique case (c) inside
            [ChUpA:ChUpZ]:    code = sextet_t'(c - ChUpA);
            [ChLoA:ChLoZ]:    code = sextet_t'(c - ChLoA + 8'd26);
            [ChZero:ChNine]:  code = sextet_t'(c - ChZero + 8'd52);
            ChPlus, ChMinus:  code = 7'd62;
            ChSlash, ChUnder: code = 7'd63;
            ChEqual:          code = PadCode;
            default:          code = BadCode;
        endcase
        return code;
    endfunction

endpackage

>>> hdl/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, gathers groups of four sextets and turns each finished
// group into a job of one to three results for the back end.
// ----------------------------------------------------------------------------
module b64d_front
    import b64d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_stall,
    input  char_word_t char_word,
    input  logic       q_full,
    output logic       push,
    output job_t       push_job
);

    logic [1:0] pos_reg, pos_next;
    sextet_t    held_reg [3];
    sextet_t    held_next [3];
    logic       halted_reg, halted_next;

    logic       accept;
    logic       eot;
    sextet_t    code;
    sextet_t    v0, v1, v2, v3;
    logic       pair_ok;
    logic       have_b1, have_b2;
    logic [7:0] b0, b1, b2;

    // The only reason to hold off a word is a full job queue.
    assign char_stall = q_full;
    assign accept     = char_valid && !q_full;
    assign eot        = char_word.end_of_text;
    assign code       = sextet_of(char_word.char_code);

    // Assemble the group: held codes, then the new code, then pads.
    assign v0 = (pos_reg == 2'd0) ? code : held_reg[0];
    assign v1 = (pos_reg > 2'd1) ? held_reg[1] : ((pos_reg == 2'd1) ? code : PadCode);
    assign v2 = (pos_reg > 2'd2) ? held_reg[2] : ((pos_reg == 2'd2) ? code : PadCode);
    assign v3 = (pos_reg == 2'd3) ? code : PadCode;

    // Decode the group into bytes.
    assign pair_ok = (v0 != BadCode) && (v1 != BadCode);
    assign have_b1 = !v2[6];
    assign have_b2 = have_b1 && !v3[6];
    assign b0      = {v0[5:0], 2'b00} | {5'b0, v1[6:4]};
    assign b1      = {v1[3:0], v2[5:2]};
    assign b2      = {v2[1:0], v3[5:0]};

    // Group and halt control.
    always_comb
    begin
        pos_next    = pos_reg;
        held_next   = held_reg;
        halted_next = halted_reg;
        push        = 1'b0;
        push_job    = '0;
        if (accept)
        begin
            if (halted_reg)
            begin
                // Characters are dropped until the end of the string.
                if (eot)
                begin
                    push          = 1'b1;
                    push_job.last = 1'b1;
                    push_job.halt = 1'b1;
                    halted_next   = 1'b0;
                end
            end
            else if ((pos_reg != 2'd3) && !eot)
            begin
                held_next[pos_reg] = code;
                pos_next           = pos_reg + 2'd1;
            end
            else
            begin
                pos_next = 2'd0;
                if (!pair_ok)
                begin
                    // A bad leading code stops this string.
                    if (eot)
                    begin
                        push          = 1'b1;
                        push_job.last = 1'b1;
                        push_job.halt = 1'b1;
                    end
                    else
                    begin
                        halted_next = 1'b1;
                    end
                end
                else
                begin
                    push              = 1'b1;
                    push_job.bytes[0] = b0;
                    push_job.bytes[1] = have_b1 ? b1 : 8'd0;
                    push_job.bytes[2] = have_b2 ? b2 : 8'd0;
                    push_job.last_idx = have_b2 ? 2'd2 : (have_b1 ? 2'd1 : 2'd0);
                    push_job.present  = 1'b1;
                    push_job.last     = eot;
                end
            end
        end
    end

    // Control state resets; held codes are read only once written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 2'd0;
            halted_reg <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            halted_reg <= halted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

`ifndef SYNTHESIS
    // A job without bytes only ever closes a halted string.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !push_job.present) |-> (push_job.last && push_job.halt))
        else $error("empty job that is not a halted end of string");

    // The end of a string returns the front to its reset state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && eot) |=> (pos_reg == 2'd0) && !halted_reg)
        else $error("state not cleared after end of string");

    // While halted no partial group is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> (pos_reg == 2'd0))
        else $error("group position nonzero while halted");
`endif

endmodule

>>> hdl/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue
// Short FIFO of decoded jobs between the front and the back end.
// ----------------------------------------------------------------------------
module b64d_queue
    import b64d_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic empty,
    output job_t head
);

    job_t           mem_reg [QDepth];
    logic [QAw-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QAw:0]   count_reg, count_next;

    assign full  = (count_reg == (QAw + 1)'(QDepth));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Job storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> hdl/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// Takes jobs from the queue and sends their results one word per cycle while
// the receiver does not stall, through a registered output stage.
// ----------------------------------------------------------------------------
module b64d_back
    import b64d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  job_t       head,
    output logic       pop,
    output logic       byte_valid,
    input  logic       byte_stall,
    output byte_word_t byte_word
);

    logic [1:0] sub_reg, sub_next;
    logic       out_valid_reg, out_valid_next;
    byte_word_t out_word_reg, out_word_next;
    logic       load;
    logic       job_done;

    // Load a new result when the output stage is free or being emptied.
    assign load     = !q_empty && (!out_valid_reg || !byte_stall);
    assign job_done = (sub_reg == head.last_idx);
    assign pop      = load && job_done;

    always_comb
    begin
        sub_next       = sub_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        if (load)
        begin
            out_valid_next             = 1'b1;
            out_word_next.data_byte    = head.bytes[sub_reg];
            out_word_next.byte_present = head.present;
            out_word_next.final_result = head.last && job_done;
            out_word_next.halted_flag  = head.halt;
            sub_next                   = job_done ? 2'd0 : (sub_reg + 2'd1);
        end
        else if (!byte_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sub_reg       <= sub_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    assign byte_valid = out_valid_reg;
    assign byte_word  = out_word_reg;

`ifndef SYNTHESIS
    // Partway through a job its entry is still at the head of the queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        (sub_reg != 2'd0) |-> !q_empty)
        else $error("job index set with an empty queue");

    // The result index never runs past the job's last result.
    assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty |-> (sub_reg <= head.last_idx))
        else $error("result index beyond job");

    // A halted result carries no byte and ends the string.
    assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid && byte_word.halted_flag) |->
            (!byte_word.byte_present && byte_word.final_result))
        else $error("halted result with a byte or not final");
`endif

endmodule

>>> hdl/base64url_decoder.sv
// ----------------------------------------------------------------------------
// base64url_decoder
// Streaming decoder for standard and URL-safe base64, one character a word.
// ----------------------------------------------------------------------------
// Input channel char_*: one character per word with an end-of-text mark.
// Output channel byte_*: one decoded result per word; the last result of a
// string carries final_result, and a string that yields no byte at its end
// gives one empty word with final_result set.
// Both channels move a word on a clock edge where valid is high and stall is
// low. The block takes one character every cycle while char_stall is low; a
// group of four characters gives at most three results, so output keeps pace.
// An accepted character that completes a group goes into the four-entry job
// queue, and its first result then goes into the output register.
// When the receiver stalls, the output word holds and the queue fills; once
// four jobs wait, char_stall rises until the back end drains a job.
// Reset clears the group position, the halt state, the queue and the output
// stage; the block accepts characters from the first cycle after reset.
// ----------------------------------------------------------------------------
module base64url_decoder
    import b64d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_stall,
    input  char_word_t char_word,
    output logic       byte_valid,
    input  logic       byte_stall,
    output byte_word_t byte_word
);

    logic push;
    job_t push_job;
    logic pop;
    logic q_full;
    logic q_empty;
    job_t head;

    // Character intake and group decode.
    b64d_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_word  (char_word),
        .q_full     (q_full),
        .push       (push),
        .push_job   (push_job)
    );

    // Job queue.
    b64d_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (head)
    );

    // Result sequencing and output register.
    b64d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .head       (head),
        .pop        (pop),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_word  (byte_word)
    );

endmodule
